// ===== sv/csvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

  localparam int FIELD_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FIELD_DEPTH);
  localparam int LEN_W       = $clog2(FIELD_DEPTH + 1);

  localparam logic [7:0] DQ_BYTE    = 8'd34;
  localparam logic [7:0] TAB_BYTE   = 8'd9;
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] SPACE_BYTE = 8'd32;

  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;
  localparam logic [7:0] ESC_RESET   = 8'd92;

  localparam logic [1:0] CFG_SEP   = 2'd0;
  localparam logic [1:0] CFG_QUOTE = 2'd1;
  localparam logic [1:0] CFG_ESC   = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_QUOTE = 2'd1,
    ERR_SEP   = 2'd2,
    ERR_OVF   = 2'd3
  } err_code_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } fbuf_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } fbuf_rd_t;

  // space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c == SPACE_BYTE) || ((c >= TAB_BYTE) && (c <= CR_BYTE));
  endfunction

endpackage

`default_nettype wire

// ===== sv/csvt_fbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csvt_fbuf (
  input  logic                clk,
  input  csvt_pkg::fbuf_wr_t  wr,
  input  csvt_pkg::fbuf_rd_t  rd,
  output logic [7:0]          rd_data_a,
  output logic [7:0]          rd_data_b
);
  import csvt_pkg::*;

  logic [7:0] mem_r [FIELD_DEPTH];
  logic [7:0] rda_r;
  logic [7:0] rdb_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rda_r <= mem_r[rd.addr_a];
    rdb_r <= mem_r[rd.addr_b];
  end

  assign rd_data_a = rda_r;
  assign rd_data_b = rdb_r;

endmodule

`default_nettype wire

// ===== sv/csvt_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csvt_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_line_end,
  input  logic               in_empty_line,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_field_last,
  output logic               out_field_empty,
  output logic               out_row_last,
  output logic               out_empty_row,
  output logic [1:0]         out_error_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output csvt_pkg::fbuf_wr_t wr,
  output csvt_pkg::fbuf_rd_t rd,
  input  logic [7:0]         rd_data_a,
  input  logic [7:0]         rd_data_b
);
  import csvt_pkg::*;

  typedef enum logic [6:0] {
    PH_LINE_START  = 7'b0000001,
    PH_FIELD_START = 7'b0000010,
    PH_PLAIN       = 7'b0000100,
    PH_QUOTED      = 7'b0001000,
    PH_ESCAPED     = 7'b0010000,
    PH_CLOSED      = 7'b0100000,
    PH_DROP        = 7'b1000000
  } ph_t;

  typedef enum logic [4:0] {
    SQ_IDLE = 5'b00001,
    SQ_TRD  = 5'b00010,
    SQ_TCHK = 5'b00100,
    SQ_WRD  = 5'b01000,
    SQ_WCHK = 5'b10000
  } sq_t;

  sq_t             sq_r, sq_nxt;
  ph_t             ph_r, ph_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic            atab_r, atab_nxt;
  logic [LEN_W-1:0] lo_r, lo_nxt;
  logic [LEN_W-1:0] hi_r, hi_nxt;
  logic            re_r, re_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic            prev_dq_r, prev_dq_nxt;
  logic [7:0]      sep_r, sep_nxt;
  logic [7:0]      quote_r, quote_nxt;
  logic [7:0]      esc_r, esc_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_fl_r, out_fl_nxt;
  logic            out_fe_r, out_fe_nxt;
  logic            out_rl_r, out_rl_nxt;
  logic            out_er_r, out_er_nxt;
  logic [1:0]      out_ec_r, out_ec_nxt;

  logic            in_fire;
  logic            out_free;
  logic            fresh;
  logic [LEN_W-1:0] base_len;
  logic            base_atab;
  logic            st_skip;
  logic            st_ovf;
  logic [LEN_W-1:0] st_len;
  logic            st_atab;
  logic [7:0]      st_data;
  logic [LEN_W-1:0] hi_m1;

  logic            act_store;
  logic            act_emit;
  logic            act_err;
  logic            plain_path;
  logic            emit_re;
  logic            empty_res;
  err_code_t       err_code;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (sq_r == SQ_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // store path: a fresh field starts empty and not after a tab
  assign fresh     = (ph_r == PH_LINE_START) || (ph_r == PH_FIELD_START);
  assign base_len  = fresh ? '0 : len_r;
  assign base_atab = fresh ? 1'b0 : atab_r;
  assign st_skip   = base_atab && is_ws(in_byte);
  assign st_ovf    = !st_skip && (base_len == LEN_W'(FIELD_DEPTH));
  assign st_len    = st_skip ? base_len : base_len + LEN_W'(1);
  assign st_atab   = st_skip ? base_atab : (in_byte == TAB_BYTE);
  assign st_data   = (in_byte == TAB_BYTE) ? SPACE_BYTE : in_byte;

  assign hi_m1     = hi_r - LEN_W'(1);
  assign rd.addr_a = lo_r[ADDR_W-1:0];
  assign rd.addr_b = hi_m1[ADDR_W-1:0];

  assign wr.addr   = base_len[ADDR_W-1:0];
  assign wr.data   = st_data;
  assign wr.en     = in_fire && act_store && !st_skip && !st_ovf;

  // parse decision for the byte on the input
  always_comb begin
    act_store  = 1'b0;
    act_emit   = 1'b0;
    act_err    = 1'b0;
    plain_path = 1'b0;
    emit_re    = 1'b0;
    empty_res  = 1'b0;
    err_code   = ERR_NONE;
    if (in_empty_line) begin
      empty_res = (ph_r == PH_LINE_START);
    end else begin
      unique case (ph_r)
        PH_LINE_START, PH_FIELD_START: begin
          if (in_byte == quote_r) begin
            if (in_line_end) begin
              act_err  = 1'b1;
              err_code = ERR_QUOTE;
            end
          end else begin
            plain_path = 1'b1;
          end
        end
        PH_PLAIN: begin
          plain_path = 1'b1;
        end
        PH_QUOTED: begin
          if (in_byte == esc_r) begin
            if (in_line_end) begin
              act_err  = 1'b1;
              err_code = ERR_QUOTE;
            end
          end else if (in_byte == quote_r) begin
            if (in_line_end) begin
              act_emit = 1'b1;
              emit_re  = 1'b1;
            end
          end else begin
            act_store = 1'b1;
            if (st_ovf) begin
              act_err  = 1'b1;
              err_code = ERR_OVF;
            end else if (in_line_end) begin
              act_err  = 1'b1;
              err_code = ERR_QUOTE;
            end
          end
        end
        PH_ESCAPED: begin
          act_store = 1'b1;
          if (st_ovf) begin
            act_err  = 1'b1;
            err_code = ERR_OVF;
          end else if (in_line_end) begin
            act_err  = 1'b1;
            err_code = ERR_QUOTE;
          end
        end
        PH_CLOSED: begin
          if (in_byte == sep_r) begin
            act_emit = 1'b1;
            emit_re  = in_line_end;
          end else begin
            act_err  = 1'b1;
            err_code = ERR_SEP;
          end
        end
        PH_DROP: begin
        end
        default: begin
        end
      endcase
      if (plain_path) begin
        if (in_byte == sep_r) begin
          act_emit = 1'b1;
          emit_re  = in_line_end;
        end else begin
          act_store = 1'b1;
          if (st_ovf) begin
            act_err  = 1'b1;
            err_code = ERR_OVF;
          end else if (in_line_end) begin
            act_emit = 1'b1;
            emit_re  = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    sq_nxt        = sq_r;
    ph_nxt        = ph_r;
    len_nxt       = len_r;
    atab_nxt      = atab_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    re_nxt        = re_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    prev_dq_nxt   = prev_dq_r;
    sep_nxt       = sep_r;
    quote_nxt     = quote_r;
    esc_nxt       = esc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_fl_nxt    = out_fl_r;
    out_fe_nxt    = out_fe_r;
    out_rl_nxt    = out_rl_r;
    out_er_nxt    = out_er_r;
    out_ec_nxt    = out_ec_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEP:   sep_nxt   = cfg_data;
        CFG_QUOTE: quote_nxt = cfg_data;
        CFG_ESC:   esc_nxt   = cfg_data;
        default: begin
        end
      endcase
    end

    unique case (sq_r)
      SQ_IDLE: begin
        if (in_fire && !in_empty_line) begin
          if (fresh) begin
            len_nxt  = '0;
            atab_nxt = 1'b0;
            ph_nxt   = (in_byte == quote_r) ? PH_QUOTED : PH_PLAIN;
          end
          if (ph_r == PH_QUOTED) begin
            if (in_byte == esc_r) begin
              ph_nxt = PH_ESCAPED;
            end else if (in_byte == quote_r) begin
              ph_nxt = PH_CLOSED;
            end
          end
          if (ph_r == PH_ESCAPED) begin
            ph_nxt = PH_QUOTED;
          end
          if ((ph_r == PH_DROP) && in_line_end) begin
            ph_nxt   = PH_LINE_START;
            len_nxt  = '0;
            atab_nxt = 1'b0;
          end
          if (act_store && !st_ovf) begin
            len_nxt  = st_len;
            atab_nxt = st_atab;
          end
          if (act_emit) begin
            hi_nxt   = act_store ? st_len : base_len;
            lo_nxt   = '0;
            re_nxt   = emit_re;
            sq_nxt   = SQ_TRD;
            len_nxt  = '0;
            atab_nxt = 1'b0;
            ph_nxt   = emit_re ? PH_LINE_START : PH_FIELD_START;
          end
          if (act_err) begin
            len_nxt  = '0;
            atab_nxt = 1'b0;
            ph_nxt   = in_line_end ? PH_LINE_START : PH_DROP;
          end
        end
        if (in_fire && (act_err || empty_res)) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_fl_nxt    = empty_res;
          out_fe_nxt    = empty_res;
          out_rl_nxt    = 1'b1;
          out_er_nxt    = empty_res;
          out_ec_nxt    = empty_res ? ERR_NONE : err_code;
        end
      end
      SQ_TRD: begin
        sq_nxt = SQ_TCHK;
      end
      SQ_TCHK: begin
        // strip order: trailing whitespace, leading whitespace, then an outer '"' pair
        if ((lo_r < hi_r) && is_ws(rd_data_b)) begin
          hi_nxt = hi_m1;
          sq_nxt = SQ_TRD;
        end else if ((lo_r < hi_r) && is_ws(rd_data_a)) begin
          lo_nxt = lo_r + LEN_W'(1);
          sq_nxt = SQ_TRD;
        end else if (((hi_r - lo_r) >= LEN_W'(2)) && (rd_data_a == DQ_BYTE) &&
                     (rd_data_b == DQ_BYTE)) begin
          lo_nxt = lo_r + LEN_W'(1);
          hi_nxt = hi_m1;
          sq_nxt = SQ_TRD;
        end else begin
          pend_v_nxt  = 1'b0;
          prev_dq_nxt = 1'b0;
          sq_nxt      = SQ_WRD;
        end
      end
      SQ_WRD: begin
        if (lo_r < hi_r) begin
          sq_nxt = SQ_WCHK;
        end else if (out_free) begin
          // close the field: held byte goes out last, or an empty field
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_v_r ? pend_r : 8'd0;
          out_fl_nxt    = 1'b1;
          out_fe_nxt    = !pend_v_r;
          out_rl_nxt    = re_r;
          out_er_nxt    = 1'b0;
          out_ec_nxt    = ERR_NONE;
          pend_v_nxt    = 1'b0;
          sq_nxt        = SQ_IDLE;
        end
      end
      SQ_WCHK: begin
        if ((rd_data_a == DQ_BYTE) && prev_dq_r) begin
          lo_nxt = lo_r + LEN_W'(1);
          sq_nxt = SQ_WRD;
        end else if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = pend_r;
            out_fl_nxt    = 1'b0;
            out_fe_nxt    = 1'b0;
            out_rl_nxt    = 1'b0;
            out_er_nxt    = 1'b0;
            out_ec_nxt    = ERR_NONE;
          end
          pend_v_nxt  = 1'b1;
          pend_nxt    = rd_data_a;
          prev_dq_nxt = (rd_data_a == DQ_BYTE);
          lo_nxt      = lo_r + LEN_W'(1);
          sq_nxt      = SQ_WRD;
        end
      end
      default: begin
        sq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= SQ_IDLE;
      ph_r        <= PH_LINE_START;
      len_r       <= '0;
      atab_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      prev_dq_r   <= 1'b0;
      out_valid_r <= 1'b0;
      sep_r       <= SEP_RESET;
      quote_r     <= QUOTE_RESET;
      esc_r       <= ESC_RESET;
    end else begin
      sq_r        <= sq_nxt;
      ph_r        <= ph_nxt;
      len_r       <= len_nxt;
      atab_r      <= atab_nxt;
      pend_v_r    <= pend_v_nxt;
      prev_dq_r   <= prev_dq_nxt;
      out_valid_r <= out_valid_nxt;
      sep_r       <= sep_nxt;
      quote_r     <= quote_nxt;
      esc_r       <= esc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    re_r       <= re_nxt;
    pend_r     <= pend_nxt;
    out_byte_r <= out_byte_nxt;
    out_fl_r   <= out_fl_nxt;
    out_fe_r   <= out_fe_nxt;
    out_rl_r   <= out_rl_nxt;
    out_er_r   <= out_er_nxt;
    out_ec_r   <= out_ec_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_field_last  = out_fl_r;
  assign out_field_empty = out_fe_r;
  assign out_row_last    = out_rl_r;
  assign out_empty_row   = out_er_r;
  assign out_error_code  = out_ec_r;

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r != SQ_IDLE) |-> (lo_r <= hi_r))
    else $error("trim window inverted");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(FIELD_DEPTH))
    else $error("field length past buffer depth");

  a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && act_emit) |=> (sq_r == SQ_TRD))
    else $error("field end did not start trimming");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r == SQ_IDLE) |-> !pend_v_r)
    else $error("byte left pending at idle");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (act_err || empty_res)) |=> (out_valid_r && out_rl_r))
    else $error("error or empty row result not loaded");

endmodule

`default_nettype wire

// ===== sv/csv_field_tokenizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_byte, in_line_end, in_empty_line
// out_     output     out_valid / out_ready  out_byte, out_field_last, out_field_empty,
//                                            out_row_last, out_empty_row, out_error_code
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte that does not end a field, an error or an empty row is taken while in_ready is
// high (sequencer idle, output register free). A byte that ends a field drops in_ready
// while the sequencer reads the buffer's registered ports and checks, per trim step (each
// stripped byte or pair), then per byte left, collapsed quotes included, then closes the field.
// Reset (rst_n low, synchronous) clears the sequencer, parse phase, field length, tab
// and pending flags, output valid and the separator, quote and escape registers; the
// field buffer needs no clearing pass. A stalled output holds the walk in place.

module csv_field_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_line_end,
  input  logic       in_empty_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_field_last,
  output logic       out_field_empty,
  output logic       out_row_last,
  output logic       out_empty_row,
  output logic [1:0] out_error_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import csvt_pkg::*;

  fbuf_wr_t   buf_wr;
  fbuf_rd_t   buf_rd;
  logic [7:0] buf_rda;
  logic [7:0] buf_rdb;

  csvt_fbuf u_fbuf (
    .clk       (clk),
    .wr        (buf_wr),
    .rd        (buf_rd),
    .rd_data_a (buf_rda),
    .rd_data_b (buf_rdb)
  );

  csvt_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_line_end     (in_line_end),
    .in_empty_line   (in_empty_line),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_field_last  (out_field_last),
    .out_field_empty (out_field_empty),
    .out_row_last    (out_row_last),
    .out_empty_row   (out_empty_row),
    .out_error_code  (out_error_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .wr              (buf_wr),
    .rd              (buf_rd),
    .rd_data_a       (buf_rda),
    .rd_data_b       (buf_rdb)
  );

endmodule

`default_nettype wire
